// ===== rtl/core/sdik_pkg.sv =====
// ----------------------------------------------------------------------------
// Swerve drive inverse kinematics package
// Shared types, constants and tables for the swerve kinematics block.
// ----------------------------------------------------------------------------
package sdik_pkg;

	localparam int VEL_W = 16;
	localparam int LEN_W = 12;
	localparam int RAD_W = 16;
	localparam int SPD_W = 20;
	localparam int ANG_W = 16;
	localparam int IDX_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

	localparam logic [LEN_W-1:0] LENGTH_RESET = 12'd614;
	localparam logic [LEN_W-1:0] WIDTH_RESET  = 12'd819;
	localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd2130;

	// Wheel velocity component width, 2^-21 m/s.
	localparam int WV_W = 32;
	// CORDIC datapath width after normalization.
	localparam int CX_W = 34;
	localparam int ACC_W = 28;
	localparam int SQ_W = 64;
	localparam int MAG_W = 32;

	localparam logic [26:0] SPEED_K = 27'd80105306;
	localparam logic signed [ACC_W-1:0] HALF_PI_Q24 = 28'sd26353589;
	localparam logic [SPD_W-1:0] SPEED_MAX = 20'hFFFFF;
	localparam logic signed [ANG_W-1:0] ANGLE_MAX = 16'sd25736;

	typedef struct packed {
		logic                    use_auto;
		logic signed [VEL_W-1:0] auto_vel_x;
		logic signed [VEL_W-1:0] auto_vel_y;
		logic signed [VEL_W-1:0] auto_yaw_rate;
		logic signed [VEL_W-1:0] manual_vel_x;
		logic signed [VEL_W-1:0] manual_vel_y;
		logic signed [VEL_W-1:0] manual_yaw_rate;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]        wheel_index;
		logic [SPD_W-1:0]        drive_spd;
		logic signed [ANG_W-1:0] steer_ang;
		logic                    last_wheel;
	} res_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_t;

	function automatic logic signed [ACC_W-1:0] atan_q24(input logic [4:0] i);
		logic signed [ACC_W-1:0] r;
		begin
			case (i)
				5'd0: r = 28'sd13176795;
				5'd1: r = 28'sd7778716;
				5'd2: r = 28'sd4110060;
				5'd3: r = 28'sd2086331;
				5'd4: r = 28'sd1047214;
				5'd5: r = 28'sd524117;
				5'd6: r = 28'sd262123;
				5'd7: r = 28'sd131069;
				default: r = (i < 5'd24) ? (28'sd65536 >>> (i - 5'd8)) : 28'sd0;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== rtl/core/sdik_if.sv =====
// ----------------------------------------------------------------------------
// Swerve drive stream interfaces
// Valid/ready channel with a generic payload type.
// ----------------------------------------------------------------------------
interface sdik_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/swerve_drive_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// Swerve drive inverse kinematics
// Four-wheel swerve kinematics: wheel steering angles and speeds per command.
// ----------------------------------------------------------------------------
// Usage: a command transaction on cmd carries both velocity sets and the
// selection flag. The block answers with four transactions on res, wheels
// 0 to 3 in order, with last_wheel set on the fourth. The cfg channel writes
// chassis length, width and wheel radius by register index; it is always
// ready and must only be used while the block is idle.
// The single wheel sequencer feeds one wheel per cycle into the datapath
// pipeline while the output is not stalled; it accepts a new command
// while it issues the fourth wheel of the current one.
// Pipeline: behind the sequencer lie three input stages, a square root unit
// of 32 steps, six normalization stages, the pre-rotation, the CORDIC chain,
// the rounding stage, a 20-step division and the output register.
// Reset clears all valid bits and loads the register defaults. When the
// receiver stalls, the whole pipeline holds; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module swerve_drive_inverse_kinematics #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input logic clk,
	input logic arst_n,
	sdik_if.sink   cmd,
	sdik_if.sink   cfg,
	sdik_if.source res
);
	import sdik_pkg::*;

	localparam int IT = (ANGLE_ITERATIONS > 24) ? 24 : ANGLE_ITERATIONS;
	localparam int NSQ = 32;
	localparam int NORM = 6;

	logic [LEN_W-1:0] len_q, wid_q;
	logic [RAD_W-1:0] rad_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LENGTH_RESET;
			wid_q <= WIDTH_RESET;
			rad_q <= RADIUS_RESET;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_LENGTH: len_q <= cfg.data.data[LEN_W-1:0];
				REG_WIDTH:  wid_q <= cfg.data.data[LEN_W-1:0];
				REG_RADIUS: rad_q <= cfg.data.data;
				default: ;
			endcase
		end
	end

	// Global stall: all stages advance together.
	logic adv;
	logic out_v_q;
	assign adv = !out_v_q || res.ready;

	// Sequencer: holds one command and issues one wheel per cycle while not stalled.
	logic                    busy_q;
	logic [IDX_W-1:0]        w_q;
	logic signed [VEL_W-1:0] x_q, y_q, z_q;
	assign cmd.ready = adv && (!busy_q || w_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			w_q <= '0;
		end else if (adv) begin
			if (cmd.valid && cmd.ready) begin
				busy_q <= 1'b1;
				w_q <= '0;
			end else if (busy_q) begin
				busy_q <= (w_q != 2'd3);
				w_q <= w_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			x_q <= cmd.data.use_auto ? cmd.data.auto_vel_x : cmd.data.manual_vel_x;
			y_q <= cmd.data.use_auto ? cmd.data.auto_vel_y : cmd.data.manual_vel_y;
			z_q <= cmd.data.use_auto ? cmd.data.auto_yaw_rate : cmd.data.manual_yaw_rate;
		end
	end

	// Stage 1: products z*py and z*px, scaled x and y velocities and the idle flag.
	logic                    v_s1, idle_s1;
	logic [IDX_W-1:0]        w_s1;
	logic signed [WV_W-1:0]  zpy_s1, zpx_s1, xs_s1, ys_s1, px_s1, py_s1;
	logic signed [LEN_W:0]   px_c, py_c;
	assign px_c = (w_q == 2'd0 || w_q == 2'd3) ? $signed({1'b0, len_q}) : -$signed({1'b0, len_q});
	assign py_c = (w_q == 2'd0 || w_q == 2'd1) ? $signed({1'b0, wid_q}) : -$signed({1'b0, wid_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= busy_q;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1 <= w_q;
			idle_s1 <= (x_q == 0) && (y_q == 0) && (z_q == 0);
			zpy_s1 <= WV_W'(z_q) * WV_W'(py_c);
			zpx_s1 <= WV_W'(z_q) * WV_W'(px_c);
			xs_s1 <= WV_W'(x_q) <<< 11;
			ys_s1 <= WV_W'(y_q) <<< 11;
			px_s1 <= WV_W'(px_c);
			py_s1 <= WV_W'(py_c);
		end
	end

	// Stage 2: wheel velocity vector, or (-py, px) for an all-zero command.
	logic                   v_s2, idle_s2;
	logic [IDX_W-1:0]       w_s2;
	logic signed [WV_W-1:0] vx_s2, vy_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s2 <= w_s1;
			idle_s2 <= idle_s1;
			vx_s2 <= idle_s1 ? -py_s1 : xs_s1 - zpy_s1;
			vy_s2 <= idle_s1 ? px_s1 : ys_s1 + zpx_s1;
		end
	end

	// Stage 3: squares.
	logic                   v_s3, idle_s3;
	logic [IDX_W-1:0]       w_s3;
	logic signed [WV_W-1:0] vx_s3, vy_s3;
	logic [SQ_W-1:0]        sqx_s3, sqy_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s3 <= w_s2;
			idle_s3 <= idle_s2;
			vx_s3 <= vx_s2;
			vy_s3 <= vy_s2;
			sqx_s3 <= SQ_W'(vx_s2) * SQ_W'(vx_s2);
			sqy_s3 <= SQ_W'(vy_s2) * SQ_W'(vy_s2);
		end
	end

	// Square root pipeline: one result bit per stage, with the vector in tow.
	logic [SQ_W-1:0]        rem_p [NSQ+1];
	logic [MAG_W-1:0]       root_p [NSQ+1];
	logic signed [WV_W-1:0] ax_p [NSQ+1], ay_p [NSQ+1];
	logic                   pv_p [NSQ+1], pi_p [NSQ+1];
	logic [IDX_W-1:0]       pw_p [NSQ+1];

	always_comb begin
		rem_p[0] = sqx_s3 + sqy_s3;
		root_p[0] = '0;
		ax_p[0] = vx_s3;
		ay_p[0] = vy_s3;
		pv_p[0] = v_s3;
		pi_p[0] = idle_s3;
		pw_p[0] = w_s3;
	end

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		localparam int SH = 2 * (NSQ - 1 - k);
		logic [SQ_W-1:0] trial;
		logic [SQ_W-1:0] rem_q;
		logic [MAG_W-1:0] root_q;
		logic signed [WV_W-1:0] ax_q, ay_q;
		logic pi_q;
		logic [IDX_W-1:0] pw_q;
		logic pv_q;
		assign trial = ({32'd0, root_p[k]} << (SH + 2)) | (SQ_W'(1) << SH);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) pv_q <= 1'b0;
			else if (adv) pv_q <= pv_p[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (rem_p[k] >= trial) begin
					rem_q <= rem_p[k] - trial;
					root_q <= {root_p[k][MAG_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_p[k];
					root_q <= {root_p[k][MAG_W-2:0], 1'b0};
				end
				ax_q <= ax_p[k];
				ay_q <= ay_p[k];
				pi_q <= pi_p[k];
				pw_q <= pw_p[k];
			end
		end
		assign rem_p[k+1] = rem_q;
		assign root_p[k+1] = root_q;
		assign ax_p[k+1] = ax_q;
		assign ay_p[k+1] = ay_q;
		assign pi_p[k+1] = pi_q;
		assign pw_p[k+1] = pw_q;
		assign pv_p[k+1] = pv_q;
	end

	// Normalization: up to 32 doublings, in stages of 16,8,4,2,1,1.
	logic [CX_W-1:0]  nx_p [NORM+1], ny_p [NORM+1];
	logic             nz_p [NORM+1], nv_p [NORM+1], ni_p [NORM+1];
	logic [IDX_W-1:0] nw_p [NORM+1];
	logic [MAG_W-1:0] nr_p [NORM+1];
	assign nx_p[0] = CX_W'(ax_p[NSQ]);
	assign ny_p[0] = CX_W'(ay_p[NSQ]);
	assign nz_p[0] = (ax_p[NSQ] == 0) && (ay_p[NSQ] == 0);
	assign nv_p[0] = pv_p[NSQ];
	assign ni_p[0] = pi_p[NSQ];
	assign nw_p[0] = pw_p[NSQ];
	assign nr_p[0] = root_p[NSQ];

	for (genvar k = 0; k < NORM; k++) begin : g_norm
		localparam int S = (k < 5) ? (16 >> k) : 1;
		logic signed [CX_W-1:0] sx, sy, tx, ty;
		logic big;
		logic [CX_W-1:0] x_q, y_q;
		logic z_q, i_q, v_q;
		logic [IDX_W-1:0] w_q2;
		logic [MAG_W-1:0] r_q;
		assign sx = $signed(nx_p[k]);
		assign sy = $signed(ny_p[k]);
		assign tx = sx <<< S;
		assign ty = sy <<< S;
		// The first stages shift only while both magnitudes stay within 2^29;
		// the last stage doubles whenever the larger one is still below 2^29.
		assign big = ((sx < 0 ? -sx : sx) >= (CX_W'(1) <<< 29))
			|| ((sy < 0 ? -sy : sy) >= (CX_W'(1) <<< 29))
			|| ((k < NORM - 1) && ((tx >>> S) != sx || (ty >>> S) != sy
			|| ((tx < 0 ? -tx : tx) > (CX_W'(1) <<< 29))
			|| ((ty < 0 ? -ty : ty) > (CX_W'(1) <<< 29))));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q <= 1'b0;
			else if (adv) v_q <= nv_p[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				x_q <= (big || nz_p[k]) ? nx_p[k] : tx;
				y_q <= (big || nz_p[k]) ? ny_p[k] : ty;
				z_q <= nz_p[k];
				i_q <= ni_p[k];
				w_q2 <= nw_p[k];
				r_q <= nr_p[k];
			end
		end
		assign nx_p[k+1] = x_q;
		assign ny_p[k+1] = y_q;
		assign nz_p[k+1] = z_q;
		assign nv_p[k+1] = v_q;
		assign ni_p[k+1] = i_q;
		assign nw_p[k+1] = w_q2;
		assign nr_p[k+1] = r_q;
	end

	// Quadrant pre-rotation.
	logic signed [CX_W-1:0] cx_p [IT+1], cy_p [IT+1];
	logic signed [ACC_W-1:0] ca_p [IT+1];
	logic                   cz_p [IT+1], cv_p [IT+1], ci_p [IT+1];
	logic [IDX_W-1:0]       cw_p [IT+1];
	logic [MAG_W-1:0]       cr_p [IT+1];
	logic signed [CX_W-1:0] qx_q, qy_q;
	logic signed [ACC_W-1:0] qa_q;
	logic qz_q, qv_q, qi_q;
	logic [IDX_W-1:0] qw_q;
	logic [MAG_W-1:0] qr_q;
	logic signed [CX_W-1:0] ux, uy;
	assign ux = $signed(nx_p[NORM]);
	assign uy = $signed(ny_p[NORM]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) qv_q <= 1'b0;
		else if (adv) qv_q <= nv_p[NORM];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			if (ux < 0 && uy >= 0) begin
				qx_q <= uy; qy_q <= -ux; qa_q <= HALF_PI_Q24;
			end else if (ux < 0) begin
				qx_q <= -uy; qy_q <= ux; qa_q <= -HALF_PI_Q24;
			end else begin
				qx_q <= ux; qy_q <= uy; qa_q <= '0;
			end
			qz_q <= nz_p[NORM];
			qi_q <= ni_p[NORM];
			qw_q <= nw_p[NORM];
			qr_q <= nr_p[NORM];
		end
	end
	assign cx_p[0] = qx_q;
	assign cy_p[0] = qy_q;
	assign ca_p[0] = qa_q;
	assign cz_p[0] = qz_q;
	assign cv_p[0] = qv_q;
	assign ci_p[0] = qi_q;
	assign cw_p[0] = qw_q;
	assign cr_p[0] = qr_q;

	for (genvar k = 0; k < IT; k++) begin : g_cordic
		logic signed [CX_W-1:0] x_q, y_q;
		logic signed [ACC_W-1:0] a_q;
		logic z_q, v_q, i_q;
		logic [IDX_W-1:0] w_q2;
		logic [MAG_W-1:0] r_q;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q <= 1'b0;
			else if (adv) v_q <= cv_p[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (cy_p[k] > 0) begin
					x_q <= cx_p[k] + (cy_p[k] >>> k);
					y_q <= cy_p[k] - (cx_p[k] >>> k);
					a_q <= ca_p[k] + atan_q24(5'(k));
				end else begin
					x_q <= cx_p[k] - (cy_p[k] >>> k);
					y_q <= cy_p[k] + (cx_p[k] >>> k);
					a_q <= ca_p[k] - atan_q24(5'(k));
				end
				z_q <= cz_p[k];
				i_q <= ci_p[k];
				w_q2 <= cw_p[k];
				r_q <= cr_p[k];
			end
		end
		assign cx_p[k+1] = x_q;
		assign cy_p[k+1] = y_q;
		assign ca_p[k+1] = a_q;
		assign cz_p[k+1] = z_q;
		assign cv_p[k+1] = v_q;
		assign ci_p[k+1] = i_q;
		assign cw_p[k+1] = w_q2;
		assign cr_p[k+1] = r_q;
	end

	// Angle rounding and speed product V * K.
	logic                    v_f1, i_f1, zr_f1;
	logic [IDX_W-1:0]        w_f1;
	logic signed [ANG_W-1:0] ang_f1;
	logic [58:0]             prod_f1;
	logic signed [ACC_W-1:0] ar;
	assign ar = (ca_p[IT] + ACC_W'(1024)) >>> 11;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_f1 <= 1'b0;
		else if (adv) v_f1 <= cv_p[IT];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			w_f1 <= cw_p[IT];
			i_f1 <= ci_p[IT] || cr_p[IT] == 0;
			zr_f1 <= (rad_q == 0);
			if (cz_p[IT]) ang_f1 <= '0;
			else if (ar > ACC_W'(ANGLE_MAX)) ang_f1 <= ANGLE_MAX;
			else if (ar < -ACC_W'(ANGLE_MAX)) ang_f1 <= -ANGLE_MAX;
			else ang_f1 <= ANG_W'(ar);
			prod_f1 <= 59'(cr_p[IT]) * 59'(SPEED_K);
		end
	end

	// Speed: the quotient saturates iff prod + R*2^23 >= (MAX+1)*R*2^24,
	// otherwise the quotient is found by a 20-step restoring division.
	localparam int DS = SPD_W;
	logic [59:0]      dn_p [DS+1];
	logic [SPD_W-1:0] dq_p [DS+1];
	logic             dv_p [DS+1], di_p [DS+1], dz_p [DS+1], dsat_p [DS+1];
	logic [IDX_W-1:0] dw_p [DS+1];
	logic signed [ANG_W-1:0] da_p [DS+1];
	logic [59:0] num0;
	assign num0 = {1'b0, prod_f1} + {20'd0, rad_q, 24'd0} / 2;
	assign dn_p[0] = num0;
	assign dq_p[0] = '0;
	assign dv_p[0] = v_f1;
	assign di_p[0] = i_f1;
	assign dz_p[0] = zr_f1;
	assign dsat_p[0] = num0 >= ({20'd0, rad_q, 24'd0} << SPD_W);
	assign dw_p[0] = w_f1;
	assign da_p[0] = ang_f1;

	for (genvar k = 0; k < DS; k++) begin : g_div
		localparam int SH = DS - 1 - k;
		logic [59:0] dd;
		logic [59:0] n_q;
		logic [SPD_W-1:0] q_q;
		logic v_q, i_q, z_q, s_q;
		logic [IDX_W-1:0] w_q2;
		logic signed [ANG_W-1:0] a_q;
		assign dd = {20'd0, rad_q, 24'd0} << SH;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q <= 1'b0;
			else if (adv) v_q <= dv_p[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!dsat_p[k] && dn_p[k] >= dd) begin
					n_q <= dn_p[k] - dd;
					q_q <= dq_p[k] | (SPD_W'(1) << SH);
				end else begin
					n_q <= dn_p[k];
					q_q <= dq_p[k];
				end
				i_q <= di_p[k];
				z_q <= dz_p[k];
				s_q <= dsat_p[k];
				w_q2 <= dw_p[k];
				a_q <= da_p[k];
			end
		end
		assign dn_p[k+1] = n_q;
		assign dq_p[k+1] = q_q;
		assign dv_p[k+1] = v_q;
		assign di_p[k+1] = i_q;
		assign dz_p[k+1] = z_q;
		assign dsat_p[k+1] = s_q;
		assign dw_p[k+1] = w_q2;
		assign da_p[k+1] = a_q;
	end

	// Output register.
	res_t out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (adv) out_v_q <= dv_p[DS];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.wheel_index <= dw_p[DS];
			out_q.steer_ang <= da_p[DS];
			out_q.last_wheel <= (dw_p[DS] == 2'd3);
			if (di_p[DS]) out_q.drive_spd <= '0;
			else if (dz_p[DS] || dsat_p[DS]) out_q.drive_spd <= SPEED_MAX;
			else out_q.drive_spd <= dq_p[DS];
		end
	end
	assign res.valid = out_v_q;
	assign res.data = out_q;

endmodule

// ===== rtl/core/sdik_checker.sv =====
// ----------------------------------------------------------------------------
// Swerve drive inverse kinematics port checker
// Observes the top-level ports and checks result ordering and handshakes.
// ----------------------------------------------------------------------------
module sdik_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic [1:0] res_index,
	input logic res_last
);
	a_last_matches: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_last == (res_index == 2'd3)))
		else $error("last_wheel does not match wheel 3");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_index))
		else $error("stalled result changed");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last ##1 res_valid |->
			res_index == $past(res_index) + 2'd1)
		else $error("wheel results out of order");
endmodule

bind swerve_drive_inverse_kinematics sdik_checker u_sdik_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_index(res.data.wheel_index),
	.res_last(res.data.last_wheel)
);
